FILE: src/rwav_pkg.sv
// Shared types and constants for the receive window / ACK vector core.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package rwav_pkg;

   // Field widths
   localparam int SEQ_W    = 32;
   localparam int WIN_W    = 16;
   localparam int GAP_W    = 10;
   localparam int BYTE_W   = 8;
   localparam int CODE_W   = 2;
   localparam int RUNF_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 10;

   // Parameter defaults
   localparam int RUN_LIMIT_DEF    = 64;
   localparam int VECTOR_BYTES_DEF = 16;

   // Backward distance marker (top bit of the distance)
   localparam logic [SEQ_W-1:0] BACKWARD_MARK = 32'h8000_0000;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_UNSUP = 2'd1;
   localparam logic [1:0] STATUS_GAP   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RELIABLE_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSSY_EN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PEND_CODE   = 2'd3;

   // Register reset values
   localparam logic [GAP_W-1:0]  MAX_GAP_RST   = 10'd960;
   localparam logic [CODE_W-1:0] PEND_CODE_RST = 2'd3;

   typedef struct packed {
      logic             reliable_mode;
      logic [SEQ_W-1:0] seq_number;
      logic [WIN_W-1:0] peer_window;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SEQ_W-1:0]  acked_seq;
      logic [WIN_W-1:0]  ack_window;
      logic [BYTE_W-1:0] vector_byte;
      logic [SEQ_W-1:0]  dropped_count;
      logic              reordered;
      logic              last;
   } rsp_type;

   // Configuration handed from the register file to the sequencer
   typedef struct packed {
      logic              reliable_en;
      logic              lossy_en;
      logic [GAP_W-1:0]  max_gap;
      logic [CODE_W-1:0] pend_code;
   } cfg_type;

   // Operations of the shared subtract unit
   typedef enum logic [1:0] {
      ALU_DIST,   // seq - expected
      ALU_INCR,   // seq + 1
      ALU_RUN     // gap - run
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_CLASS,
      ST_COMMIT,
      ST_EMIT,
      ST_ERR
   } state_type;

endpackage

`default_nettype wire

FILE: src/udp_receive_window_ack_vector_core.sv
// Top level of the receive window tracker with run-length ACK vector.
// Depends on rwav_pkg and rwav_ctrl (which holds rwav_alu).
//
// One datagram request is taken at a time. A request passes through the
// sequence distance, its classification and, on success, the window update,
// then emits one result per ACK vector byte; an error gives a single result.
// The distance, the window update and the run bytes all use the single
// subtract unit stepped by the sequencer. req_stall stays high from
// acceptance until the final result is loaded into the output register,
// and a stalled result register holds the sequencer. Configuration writes
// are always accepted and are meant to be made only while the block is idle.
`default_nettype none

module udp_receive_window_ack_vector_core #(
   parameter int RUN_LIMIT    = rwav_pkg::RUN_LIMIT_DEF,
   parameter int VECTOR_BYTES = rwav_pkg::VECTOR_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  rwav_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output rwav_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rwav_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rwav_pkg::CSR_DAT_W-1:0]    csr_data
);
   import rwav_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reliable_en <= 1'b0;
         cfg_ff.lossy_en    <= 1'b0;
         cfg_ff.max_gap     <= MAX_GAP_RST;
         cfg_ff.pend_code   <= PEND_CODE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RELIABLE_EN: cfg_ff.reliable_en <= csr_data[0];
            CSR_LOSSY_EN:    cfg_ff.lossy_en    <= csr_data[0];
            CSR_MAX_GAP:     cfg_ff.max_gap     <= csr_data[GAP_W-1:0];
            CSR_PEND_CODE:   cfg_ff.pend_code   <= csr_data[CODE_W-1:0];
            default:         cfg_ff.pend_code   <= cfg_ff.pend_code;
         endcase
      end
   end

   rwav_ctrl #(
      .RUN_LIMIT    (RUN_LIMIT),
      .VECTOR_BYTES (VECTOR_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: src/rwav_alu.sv
// Shared 32-bit subtract unit with operand selection.
// Depends on rwav_pkg.
`default_nettype none

module rwav_alu (
   input  rwav_pkg::alu_op_type             op,
   input  logic [rwav_pkg::SEQ_W-1:0]       seq,
   input  logic [rwav_pkg::SEQ_W-1:0]       expected,
   input  logic [rwav_pkg::GAP_W-1:0]       gap,
   input  logic [rwav_pkg::GAP_W-1:0]       run,
   output logic [rwav_pkg::SEQ_W-1:0]       diff
);
   import rwav_pkg::*;

   logic [SEQ_W-1:0] opa;
   logic [SEQ_W-1:0] opb;

   // Operand select
   always_comb begin
      unique case (op)
         ALU_DIST: begin
            opa = seq;
            opb = expected;
         end
         ALU_INCR: begin
            // subtracting all ones adds one
            opa = seq;
            opb = '1;
         end
         ALU_RUN: begin
            opa = SEQ_W'(gap);
            opb = SEQ_W'(run);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign diff = opa - opb;

endmodule

`default_nettype wire

FILE: src/rwav_ctrl.sv
// Sequencer, per-mode window state and result register of the core.
// Depends on rwav_pkg and rwav_alu.
`default_nettype none

module rwav_ctrl #(
   parameter int RUN_LIMIT    = rwav_pkg::RUN_LIMIT_DEF,
   parameter int VECTOR_BYTES = rwav_pkg::VECTOR_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rwav_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  rwav_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rwav_pkg::rsp_type rsp_data
);
   import rwav_pkg::*;

   localparam int GAP_CAP_I = (VECTOR_BYTES - 1) * RUN_LIMIT;
   localparam logic [12:0]      GAP_CAP = 13'(GAP_CAP_I);
   localparam logic [GAP_W-1:0] RUN_MAX = GAP_W'(RUN_LIMIT);

   state_type state_ff, state_in;

   // Per-mode tracker state: index 0 lossy, 1 reliable
   logic             started_ff  [2];
   logic             fallback_ff [2];
   logic [SEQ_W-1:0] expected_ff [2];

   // Working registers of the current request
   req_type          req_ff;
   logic [SEQ_W-1:0] dist_ff;
   logic [1:0]       status_ff;
   logic             advance_ff;
   logic [SEQ_W-1:0] dropped_ff;
   logic             reord_ff;
   logic [GAP_W-1:0] gap_ff;
   logic             first_ff;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Shared unit
   alu_op_type       alu_op;
   logic [SEQ_W-1:0] alu_diff;
   logic [GAP_W-1:0] run;

   // Classification results
   logic             mode;
   logic [WIN_W-1:0] win_eff;
   logic [SEQ_W-1:0] seq_dist;
   logic             cls_err;
   logic [1:0]       cls_status;
   logic             cls_latch;
   logic             cls_advance;
   logic [SEQ_W-1:0] cls_dropped;
   logic             cls_reord;
   logic [GAP_W-1:0] cls_gap;

   // Output controls
   logic can_load;
   logic do_accept;
   logic do_dist;
   logic do_class;
   logic do_commit;
   logic do_emit;
   logic do_err;

   assign mode    = req_ff.reliable_mode;
   assign win_eff = (req_ff.peer_window == '0) ? WIN_W'(1) : req_ff.peer_window;
   assign run     = (gap_ff > RUN_MAX) ? RUN_MAX : gap_ff;
   assign can_load = !rsp_valid_ff || !rsp_stall;

   rwav_alu u_alu (
      .op       (alu_op),
      .seq      (req_ff.seq_number),
      .expected (expected_ff[mode]),
      .gap      (gap_ff),
      .run      (run),
      .diff     (alu_diff)
   );

   // Classify the datagram against its mode's window
   always_comb begin
      cls_err     = 1'b0;
      cls_status  = STATUS_OK;
      cls_latch   = 1'b0;
      cls_advance = 1'b0;
      cls_dropped = '0;
      cls_reord   = 1'b0;
      cls_gap     = '0;
      seq_dist    = started_ff[mode] ? dist_ff : '0;
      if ((mode && !cfg.reliable_en) || (!mode && !cfg.lossy_en) || fallback_ff[mode]) begin
         cls_err    = 1'b1;
         cls_status = STATUS_UNSUP;
      end else if (seq_dist == '0) begin
         cls_advance = 1'b1;
      end else if ((seq_dist & BACKWARD_MARK) != '0) begin
         cls_reord   = 1'b1;
         cls_dropped = mode ? '0 : SEQ_W'(1);
      end else if (!mode) begin
         cls_advance = 1'b1;
         cls_dropped = seq_dist;
      end else if (seq_dist <= SEQ_W'(win_eff) && seq_dist <= SEQ_W'(cfg.max_gap)) begin
         cls_advance = 1'b1;
         cls_gap     = seq_dist[GAP_W-1:0];
         // more runs than the vector can hold
         if (13'(cls_gap) > GAP_CAP) begin
            cls_err    = 1'b1;
            cls_status = STATUS_GAP;
         end
      end else begin
         cls_err    = 1'b1;
         cls_status = STATUS_GAP;
         cls_latch  = 1'b1;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIST;
         ST_DIST:   state_in = ST_CLASS;
         ST_CLASS:  state_in = cls_err ? ST_ERR : ST_COMMIT;
         ST_COMMIT: state_in = ST_EMIT;
         ST_EMIT:   if (can_load && gap_ff == '0) state_in = ST_IDLE;
         ST_ERR:    if (can_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      do_accept = 1'b0;
      do_dist   = 1'b0;
      do_class  = 1'b0;
      do_commit = 1'b0;
      do_emit   = 1'b0;
      do_err    = 1'b0;
      alu_op    = ALU_DIST;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            do_accept = req_valid;
         end
         ST_DIST:   do_dist = 1'b1;
         ST_CLASS:  do_class = 1'b1;
         ST_COMMIT: begin
            do_commit = 1'b1;
            alu_op    = ALU_INCR;
         end
         ST_EMIT: begin
            do_emit = can_load;
            alu_op  = ALU_RUN;
         end
         ST_ERR:  do_err = can_load;
         default: req_stall = 1'b1;
      endcase
   end

   // Next result item
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (do_err) begin
         rsp_in        = '0;
         rsp_in.status = status_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
      end else if (do_emit) begin
         rsp_in               = '0;
         rsp_in.status        = STATUS_OK;
         rsp_in.acked_seq     = first_ff ? req_ff.seq_number : '0;
         rsp_in.ack_window    = first_ff ? win_eff : '0;
         rsp_in.dropped_count = first_ff ? dropped_ff : '0;
         rsp_in.reordered     = first_ff ? reord_ff : 1'b0;
         if (gap_ff != '0) begin
            rsp_in.vector_byte = {cfg.pend_code, RUNF_W'(run - GAP_W'(1))};
         end else begin
            rsp_in.vector_byte = '0;
            rsp_in.last        = 1'b1;
         end
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < 2; m++) begin
            started_ff[m]  <= 1'b0;
            fallback_ff[m] <= 1'b0;
            expected_ff[m] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_class && cls_latch) fallback_ff[mode] <= 1'b1;
         if (do_commit) begin
            started_ff[mode] <= 1'b1;
            if (advance_ff) expected_ff[mode] <= alu_diff;
         end
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (do_accept) req_ff <= req_data;
      if (do_dist) dist_ff <= alu_diff;
      if (do_class) begin
         status_ff  <= cls_status;
         advance_ff <= cls_advance;
         dropped_ff <= cls_dropped;
         reord_ff   <= cls_reord;
         gap_ff     <= cls_gap;
         first_ff   <= 1'b1;
      end
      if (do_emit) begin
         first_ff <= 1'b0;
         if (gap_ff != '0) gap_ff <= alu_diff[GAP_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: src/rwav_checker.sv
// Port-level checks for udp_receive_window_ack_vector_core, with its bind.
// Depends on rwav_pkg.
`default_nettype none

module rwav_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input rwav_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input rwav_pkg::rsp_type              rsp_data
);
   import rwav_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // One request at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Error answers are a single final item with no vector byte
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.last && rsp_data.vector_byte == '0 && rsp_data.acked_seq == '0)
      else $error("malformed error result");

   // A vector always ends with the zero byte
   a_vec_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.vector_byte == '0)
      else $error("vector not terminated");

endmodule

bind udp_receive_window_ack_vector_core rwav_checker u_rwav_checker (.*);

`default_nettype wire
